@@ hdl/audio_peak_normalizer_top_macros.svh @@
// assertion macros for the peak normaliser, empty under synthesis
`ifndef AUDIO_PEAK_NORMALIZER_TOP_MACROS_SVH
`define AUDIO_PEAK_NORMALIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define APN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define APN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define APN_ASSERT(lbl, prop, msg)
`define APN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/apn_pkg.sv @@
package apn_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int STORE_SLOTS  = 64;
  localparam int ADDR_W       = $clog2(STORE_SLOTS);
  localparam int CNT_W        = $clog2(STORE_SLOTS + 1);

  localparam int SAMPLE_W = 24;
  localparam int LEVEL_W  = 23;
  localparam int PROD_W   = SAMPLE_W + LEVEL_W;
  localparam int DEN_W    = LEVEL_W + 1;
  localparam int REM_W    = DEN_W + 1;

  // divider: quotient bits, bits per cycle
  localparam int DIV_BITS   = 24;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_BITS / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [LEVEL_W-1:0] THRESH_RESET = LEVEL_W'(1048576);
  localparam logic [LEVEL_W-1:0] TARGET_RESET = LEVEL_W'(943718);

  localparam logic signed [SAMPLE_W-1:0] MIN_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] MAX_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // register addresses (word index)
  localparam int PADDR_W = 3;
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_buffer;
  } apn_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    logic                       was_scaled;
  } apn_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak_threshold;
    logic [LEVEL_W-1:0] target_level;
  } apn_cfg_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } apn_state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_PREP,
    SC_DIV,
    SC_DONE
  } apn_scl_state_e;

  // magnitude for peak tracking, most negative code saturates
  function automatic logic [LEVEL_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = ~s + 1'b1;
    if (s == MIN_NEG) begin
      return {LEVEL_W{1'b1}};
    end else if (s[SAMPLE_W-1]) begin
      return neg[LEVEL_W-1:0];
    end else begin
      return s[LEVEL_W-1:0];
    end
  endfunction

endpackage

@@ hdl/apn_cfg_regs.sv @@
module apn_cfg_regs import apn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output apn_cfg_t           cfg_o
);

  apn_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_THRESH: cfg_d.peak_threshold = pwdata[LEVEL_W-1:0];
        REG_TARGET: cfg_d.target_level   = pwdata[LEVEL_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESH: prdata = 32'(cfg_q.peak_threshold);
      REG_TARGET: prdata = 32'(cfg_q.target_level);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_threshold <= THRESH_RESET;
      cfg_q.target_level   <= TARGET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/apn_sample_store.sv @@
module apn_sample_store import apn_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [STORE_SLOTS];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/apn_scaler.sv @@
module apn_scaler import apn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [LEVEL_W-1:0]         target_i,
  input  logic [LEVEL_W-1:0]         peak_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] result_o
);

  apn_scl_state_e state_q, state_d;

  logic                 neg_q, neg_d;
  logic [SAMPLE_W-1:0]  mag_q, mag_d;
  logic [PROD_W-1:0]    num_q, num_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_BITS-1:0]  dvd_q, dvd_d;
  logic [DIV_BITS-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [PROD_W+1:0]    n_full;
  logic [REM_W:0]       trial;
  logic [SAMPLE_W-1:0]  quo_neg;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    done_o  = 1'b0;
    n_full  = '0;
    trial   = '0;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          neg_d   = sample_i[SAMPLE_W-1];
          mag_d   = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        num_d   = PROD_W'(mag_q) * PROD_W'(target_i);
        state_d = SC_PREP;
      end
      SC_PREP: begin
        // round to nearest: floor((2*num + peak) / (2*peak))
        n_full  = {1'b0, num_q, 1'b0} + (PROD_W+2)'(peak_i);
        rem_d   = n_full[PROD_W+1 -: REM_W];
        dvd_d   = n_full[DIV_BITS-1:0];
        den_d   = {peak_i, 1'b0};
        quo_d   = '0;
        cnt_d   = '0;
        state_d = SC_DIV;
      end
      SC_DIV: begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          trial = {rem_d, dvd_d[DIV_BITS-1]};
          dvd_d = {dvd_d[DIV_BITS-2:0], 1'b0};
          if (trial >= (REM_W+1)'(den_q)) begin
            trial = trial - (REM_W+1)'(den_q);
            quo_d = {quo_d[DIV_BITS-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[DIV_BITS-2:0], 1'b0};
          end
          rem_d = trial[REM_W-1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_d = SC_DONE;
        end
      end
      SC_DONE: begin
        done_o  = 1'b1;
        state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  // sign back and clamp to the 24-bit range
  assign quo_neg = ~quo_q + 1'b1;
  always_comb begin
    if (neg_q) begin
      result_o = (quo_q >= DIV_BITS'(unsigned'(MIN_NEG))) ? MIN_NEG : signed'(quo_neg);
    end else begin
      result_o = (quo_q > DIV_BITS'(unsigned'(MAX_POS))) ? MAX_POS : signed'(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

endmodule

@@ hdl/audio_peak_normalizer_top.sv @@
// buffered peak normaliser for signed q3.20 audio
// input channel (in_valid_i/in_ready_o, in_data_i): one sample word per cycle
//   while a buffer is being filled; end_of_buffer, or the 64th word, closes it
// output channel (out_valid_o/out_ready_i, out_data_o): the whole buffer is
//   then replayed in order, last_out on its final word, was_scaled on all words
//   when the buffer peak exceeded peak_threshold
// apb port: register 0 peak_threshold at 0x0, register 1 target_level at 0x4
// replay: each word goes through memory read, load and output when unscaled,
//   and through the divider between load and output when scaled; the
//   divider is shared by all words and retires 2 quotient bits per cycle
// no input word is taken while a buffer is replayed
// a stalled receiver simply holds the output register; replay waits with it
// reset empties the buffer, clears the peak and restores the default levels;
//   the sample memory itself is not cleared
`include "audio_peak_normalizer_top_macros.svh"

module audio_peak_normalizer_top import apn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  apn_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output apn_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

  apn_state_e state_q, state_d;

  logic [CNT_W-1:0]   fill_q, fill_d;     // words stored so far
  logic [CNT_W-1:0]   count_q, count_d;   // words in the closed buffer
  logic [CNT_W-1:0]   idx_q, idx_d;       // replay position
  logic [LEVEL_W-1:0] peak_q, peak_d;
  logic               scaled_q, scaled_d;
  apn_out_t           out_q, out_d;

  apn_cfg_t            cfg;
  logic                mem_we;
  logic                mem_re;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                scl_start;
  logic                scl_done;
  logic signed [SAMPLE_W-1:0] scl_result;

  logic [LEVEL_W-1:0]  peak_new;
  logic [CNT_W-1:0]    fill_new;
  logic                last_now;

  apn_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apn_sample_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.sample_in),
    .re_i    (mem_re),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  apn_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .sample_i (signed'(mem_rdata)),
    .target_i (cfg.target_level),
    .peak_i   (peak_q),
    .done_o   (scl_done),
    .result_o (scl_result)
  );

  // running peak with the incoming word folded in
  always_comb begin
    peak_new = peak_q;
    if (abs_sat(in_data_i.sample_in) > peak_q) begin
      peak_new = abs_sat(in_data_i.sample_in);
    end
  end

  assign fill_new = fill_q + 1'b1;
  assign last_now = (idx_q + 1'b1) == count_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    count_d     = count_q;
    idx_d       = idx_q;
    peak_d      = peak_q;
    scaled_d    = scaled_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    scl_start   = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mem_we = 1'b1;
          peak_d = peak_new;
          if (in_data_i.end_of_buffer || fill_new == DEPTH_CNT) begin
            // buffer closed: decide scaling once, then replay
            count_d  = fill_new;
            scaled_d = peak_new > cfg.peak_threshold;
            fill_d   = '0;
            idx_d    = '0;
            state_d  = ST_READ;
          end else begin
            fill_d = fill_new;
          end
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        out_d.last_out   = last_now;
        out_d.was_scaled = scaled_q;
        if (scaled_q) begin
          scl_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          out_d.sample_out = signed'(mem_rdata);
          state_d          = ST_OUT;
        end
      end
      ST_DIV: begin
        if (scl_done) begin
          out_d.sample_out = scl_result;
          state_d          = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (out_q.last_out) begin
            peak_d  = '0;
            state_d = ST_FILL;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      fill_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      peak_q   <= '0;
      scaled_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      peak_q   <= peak_d;
      scaled_q <= scaled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o = out_q;

  // fill and replay never overlap
  `APN_ASSERT(a_fill_replay_excl, !(in_ready_o && out_valid_o), "fill and replay overlap")
  // the final word of a buffer hands back to fill
  `APN_ASSERT_NEXT(a_last_to_fill, out_valid_o && out_ready_i && out_data_o.last_out, in_ready_o, "no return to fill after last word")
  // divider results only arrive while the sequencer waits for them
  `APN_ASSERT(a_div_done_state, scl_done |-> (state_q == ST_DIV), "divider result outside wait")

endmodule
